// ----- src/esms_pkg.sv -----
package esms_pkg;

  // Low bits of each current sense sample that take part in the compare
  localparam int unsigned SENSE_BITS = 12;
  localparam int unsigned SenseW = 12;
  localparam logic [SenseW-1:0] SenseMask = SenseW'((1 << SENSE_BITS) - 1);

  localparam logic [11:0] LimitAReset = 12'd2048;
  localparam logic [11:0] LimitBReset = 12'd2048;
  localparam logic [15:0] TimeoutReset = 16'd600;
  localparam logic [3:0] DebounceReset = 4'd3;
  localparam logic [15:0] ElapsedMax = 16'hFFFF;

  localparam int unsigned AddrW = 4;

  typedef enum logic [1:0] {
    RegLimitA = 2'd0,
    RegLimitB = 2'd1,
    RegTimeout = 2'd2,
    RegDebounce = 2'd3
  } reg_idx_e;

  typedef enum logic [1:0] {
    ActTick = 2'd0,
    ActOpen = 2'd1,
    ActClose = 2'd2,
    ActStop = 2'd3
  } action_e;

  // Motion state, one-hot
  typedef enum logic [3:0] {
    StIdle = 4'b0001,
    StOpening = 4'b0010,
    StClosing = 4'b0100,
    StError = 4'b1000
  } mode_e;

  typedef enum logic [1:0] {
    RunIdle = 2'd0,
    RunOpening = 2'd1,
    RunClosing = 2'd2,
    RunError = 2'd3
  } run_mode_e;

  typedef enum logic [1:0] {
    DriveStop = 2'd0,
    DriveForward = 2'd1,
    DriveReverse = 2'd2
  } drive_e;

  typedef enum logic [2:0] {
    ErrOk = 3'd0,
    ErrOcA = 3'd1,
    ErrOcB = 3'd2,
    ErrFault = 3'd3,
    ErrTimeout = 3'd4
  } err_e;

  typedef enum logic [1:0] {
    CmdStarted = 2'd0,
    CmdAtTarget = 2'd1,
    CmdBusy = 2'd2
  } cmd_result_e;

  typedef enum logic [1:0] {
    LimNone = 2'd0,
    LimClose = 2'd1,
    LimOpen = 2'd2,
    LimUnreported = 2'd3
  } limit_e;

  localparam logic [4:0] HostClosed = 5'd0;
  localparam logic [4:0] HostOpen = 5'd1;
  localparam logic [4:0] HostClosing = 5'd2;
  localparam logic [4:0] HostOpening = 5'd3;
  localparam logic [4:0] HostTimeout = 5'd4;
  localparam logic [2:0] LimitCodeBase = 3'b100;

  typedef struct packed {
    logic [1:0] action;
    logic close_limit_raw;
    logic open_limit_raw;
    logic fault_n;
    logic [11:0] sense_a;
    logic [11:0] sense_b;
  } req_t;

  typedef struct packed {
    logic [1:0] motor_drive;
    logic [1:0] run_mode;
    logic [2:0] fault_cause;
    logic [1:0] command_result;
    logic [1:0] report_count;
    logic [4:0] limit_code;
    logic [4:0] host_status;
  } rsp_t;

endpackage

// ----- src/esms_req_if.sv -----
interface esms_req_if
  import esms_pkg::*;
;
  logic valid;
  logic ready;
  req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- src/esms_rsp_if.sv -----
interface esms_rsp_if
  import esms_pkg::*;
;
  logic valid;
  logic ready;
  rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- src/endstop_motor_supervisor_unit.sv -----
// Motor end stop supervisor. Takes one request per clock on req_i unless stalled, and
// returns one response per request on rsp_o, in order, via the request register and
// then the response register, with the whole update of the debounce, motion state
// and fault checks done between them. Both stages move independently, so a full rate
// stream passes at one request per cycle; a stalled response blocks new requests only
// when both registers are occupied. The four limits are set over the APB port (zero
// wait states); the user must do so only while no request is in flight (not enforced).
module endstop_motor_supervisor_unit
  import esms_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  esms_req_if.sink          req_i,
  esms_rsp_if.source        rsp_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [AddrW-1:0]  paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  // Configuration registers
  logic [11:0] lim_a_q, lim_b_q;
  logic [15:0] timeout_q;
  logic [3:0] debounce_q;
  reg_idx_e wr_idx;

  assign wr_idx = reg_idx_e'(paddr[3:2]);
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_a_q <= LimitAReset;
      lim_b_q <= LimitBReset;
      timeout_q <= TimeoutReset;
      debounce_q <= DebounceReset;
    end else if (psel && penable && pwrite) begin
      case (wr_idx)
        RegLimitA: lim_a_q <= pwdata[11:0];
        RegLimitB: lim_b_q <= pwdata[11:0];
        RegTimeout: timeout_q <= pwdata[15:0];
        RegDebounce: debounce_q <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (wr_idx)
      RegLimitA: prdata = {20'd0, lim_a_q};
      RegLimitB: prdata = {20'd0, lim_b_q};
      RegTimeout: prdata = {16'd0, timeout_q};
      RegDebounce: prdata = {28'd0, debounce_q};
      default: prdata = '0;
    endcase
  end

  // Pipeline registers
  logic in_vld_q, out_vld_q;
  req_t in_q;
  rsp_t out_q, res_d;
  logic advance;

  assign advance = in_vld_q && (!out_vld_q || rsp_o.ready);
  assign req_i.ready = !in_vld_q || advance;
  assign rsp_o.valid = out_vld_q;
  assign rsp_o.data = out_q;

  // Supervisor state
  mode_e mode_q, mode_d;
  err_e err_q, err_d;
  logic stop_q, stop_d;
  logic [15:0] elapsed_q, elapsed_d;
  logic [1:0] reported_q, reported_d;
  logic [1:0] cand_q, cand_d;
  logic [3:0] stable_q, stable_d;

  logic [1:0] code;
  logic [4:0] lcode;
  logic [3:0] stable_inc;
  logic [SenseW-1:0] sa, sb;
  logic db_rep, halt_rep, moving;
  cmd_result_e cmd_res;
  logic [1:0] target;

  assign code = in_q.close_limit_raw ? LimClose : (in_q.open_limit_raw ? LimOpen : LimNone);
  assign lcode = {LimitCodeBase, ~in_q.open_limit_raw, ~in_q.close_limit_raw};
  assign stable_inc = stable_q + 4'd1;
  assign sa = in_q.sense_a & SenseMask;
  assign sb = in_q.sense_b & SenseMask;
  assign moving = (mode_q == StOpening) || (mode_q == StClosing);
  assign target = (in_q.action == ActOpen) ? LimOpen : LimClose;

  always_comb begin
    mode_d = mode_q;
    err_d = err_q;
    stop_d = stop_q;
    elapsed_d = elapsed_q;
    reported_d = reported_q;
    cand_d = cand_q;
    stable_d = stable_q;
    db_rep = 1'b0;
    halt_rep = 1'b0;
    cmd_res = CmdStarted;
    case (action_e'(in_q.action))
      ActTick: begin
        if (code != reported_q) begin
          if (code != cand_q) begin
            cand_d = code;
            stable_d = '0;
          end else if (stable_inc >= debounce_q) begin
            reported_d = code;
            stable_d = '0;
            db_rep = 1'b1;
          end else begin
            stable_d = stable_inc;
          end
        end else begin
          stable_d = '0;
        end
        if (moving) begin
          if (elapsed_q != ElapsedMax) elapsed_d = elapsed_q + 16'd1;
          halt_rep = 1'b1;
          if (stop_q) begin
            stop_d = 1'b0;
            mode_d = StIdle;
          end else if ((mode_q == StClosing && code == LimClose) ||
                       (mode_q == StOpening && code == LimOpen)) begin
            mode_d = StIdle;
          end else if (!in_q.fault_n) begin
            err_d = ErrFault;
            mode_d = StError;
          end else if (sa > lim_a_q) begin
            err_d = ErrOcA;
            mode_d = StError;
          end else if (sb > lim_b_q) begin
            err_d = ErrOcB;
            mode_d = StError;
          end else if (elapsed_d > timeout_q) begin
            err_d = ErrTimeout;
            mode_d = StError;
          end else begin
            halt_rep = 1'b0;
          end
          if (halt_rep) begin
            reported_d = code;
            stable_d = '0;
          end
        end
      end
      ActStop: stop_d = 1'b1;
      default: begin
        if (code == target) begin
          cmd_res = CmdAtTarget;
        end else if (moving) begin
          cmd_res = CmdBusy;
        end else begin
          mode_d = (in_q.action == ActOpen) ? StOpening : StClosing;
          err_d = ErrOk;
          stop_d = 1'b0;
          elapsed_d = '0;
        end
      end
    endcase
  end

  // Result fields follow the updated state
  always_comb begin
    res_d.fault_cause = err_d;
    res_d.command_result = cmd_res;
    res_d.report_count = {1'b0, db_rep} + {1'b0, halt_rep};
    res_d.limit_code = lcode;
    case (mode_d)
      StOpening: begin
        res_d.motor_drive = DriveReverse;
        res_d.run_mode = RunOpening;
        res_d.host_status = HostOpening;
      end
      StClosing: begin
        res_d.motor_drive = DriveForward;
        res_d.run_mode = RunClosing;
        res_d.host_status = HostClosing;
      end
      StError: begin
        res_d.motor_drive = DriveStop;
        res_d.run_mode = RunError;
        res_d.host_status = (err_d == ErrTimeout) ? HostTimeout : lcode;
      end
      default: begin
        res_d.motor_drive = DriveStop;
        res_d.run_mode = RunIdle;
        if (code == LimClose) res_d.host_status = HostClosed;
        else if (code == LimOpen) res_d.host_status = HostOpen;
        else res_d.host_status = lcode;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
      mode_q <= StIdle;
      err_q <= ErrOk;
      stop_q <= 1'b0;
      elapsed_q <= '0;
      reported_q <= LimUnreported;
      cand_q <= LimNone;
      stable_q <= '0;
    end else begin
      if (req_i.ready) in_vld_q <= req_i.valid;
      if (advance) begin
        out_vld_q <= 1'b1;
        mode_q <= mode_d;
        err_q <= err_d;
        stop_q <= stop_d;
        elapsed_q <= elapsed_d;
        reported_q <= reported_d;
        cand_q <= cand_d;
        stable_q <= stable_d;
      end else if (rsp_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (req_i.ready && req_i.valid) in_q <= req_i.data;
    if (advance) out_q <= res_d;
  end

endmodule

// ----- src/esms_checker.sv -----
module esms_checker
  import esms_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       rsp_valid_i,
  input logic       rsp_ready_i,
  input rsp_t       rsp_data_i,
  input logic       pready_i
);

  // A stalled response holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_data_i))
    else $error("stalled response changed");

  // Drive direction agrees with the run mode
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |->
      ((rsp_data_i.run_mode == RunClosing) == (rsp_data_i.motor_drive == DriveForward)) &&
      ((rsp_data_i.run_mode == RunOpening) == (rsp_data_i.motor_drive == DriveReverse)))
    else $error("motor drive disagrees with run mode");

  // A fault cause is held exactly while in error
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |->
      ((rsp_data_i.run_mode == RunError) == (rsp_data_i.fault_cause != ErrOk)))
    else $error("fault cause disagrees with run mode");

  // Host status reports closing while closing
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_data_i.run_mode == RunClosing |->
      rsp_data_i.host_status == HostClosing)
    else $error("host status wrong while closing");

  assert property (@(posedge clk_i) disable iff (!rst_ni) pready_i)
    else $error("config port not ready");

endmodule

bind endstop_motor_supervisor_unit esms_checker u_esms_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .rsp_data_i  (rsp_o.data),
  .pready_i    (pready)
);

// ----- verif/esms_scoreboard_pkg.sv -----
`timescale 1ns / 100ps
package esms_scoreboard_pkg;
  import esms_pkg::*;

  class supervisor_scoreboard;
    logic [11:0] limit_a = LimitAReset;
    logic [11:0] limit_b = LimitBReset;
    logic [15:0] timeout = TimeoutReset;
    logic [3:0] debounce = DebounceReset;

    run_mode_e mode = RunIdle;
    err_e fault = ErrOk;
    bit stop_armed = 1'b0;
    logic [15:0] ticks = '0;
    limit_e shown_limit = LimUnreported;
    limit_e cand_limit = LimNone;
    logic [3:0] stable = '0;

    rsp_t awaited_status[$];
    int unsigned failures = 0;

    function void set_register(reg_idx_e idx, logic [31:0] value);
      case (idx)
        RegLimitA: limit_a = value[11:0];
        RegLimitB: limit_b = value[11:0];
        RegTimeout: timeout = value[15:0];
        RegDebounce: debounce = value[3:0];
        default: ;
      endcase
    endfunction

    function logic [31:0] register_value(reg_idx_e idx);
      case (idx)
        RegLimitA: return 32'(limit_a);
        RegLimitB: return 32'(limit_b);
        RegTimeout: return 32'(timeout);
        default: return 32'(debounce);
      endcase
    endfunction

    // Advance the supervisor by one request and queue the status it must produce
    function void note_request(req_t r);
      limit_e code;
      limit_e target;
      run_mode_e next_mode;
      logic halt;
      logic [1:0] reports;
      logic [4:0] lcode;
      logic [11:0] sa;
      logic [11:0] sb;
      rsp_t e;
      if (r.close_limit_raw) code = LimClose;
      else if (r.open_limit_raw) code = LimOpen;
      else code = LimNone;
      lcode = {LimitCodeBase, ~r.open_limit_raw, ~r.close_limit_raw};
      sa = r.sense_a & SenseMask;
      sb = r.sense_b & SenseMask;
      reports = '0;
      e = '0;
      e.command_result = CmdStarted;
      case (r.action)
        ActTick: begin
          if (code != shown_limit) begin
            if (code != cand_limit) begin
              cand_limit = code;
              stable = '0;
            end else begin
              stable = stable + 4'd1;
              if (stable >= debounce) begin
                shown_limit = code;
                stable = '0;
                reports = reports + 2'd1;
              end
            end
          end else begin
            stable = '0;
          end
          if (mode == RunOpening || mode == RunClosing) begin
            if (ticks != ElapsedMax) ticks = ticks + 16'd1;
            halt = 1'b1;
            next_mode = RunError;
            if (stop_armed) begin
              stop_armed = 1'b0;
              next_mode = RunIdle;
            end else if ((mode == RunClosing && code == LimClose) ||
                         (mode == RunOpening && code == LimOpen)) begin
              next_mode = RunIdle;
            end else if (!r.fault_n) begin
              fault = ErrFault;
            end else if (sa > limit_a) begin
              fault = ErrOcA;
            end else if (sb > limit_b) begin
              fault = ErrOcB;
            end else if (ticks > timeout) begin
              fault = ErrTimeout;
            end else begin
              halt = 1'b0;
            end
            if (halt) begin
              mode = next_mode;
              shown_limit = code;
              stable = '0;
              reports = reports + 2'd1;
            end
          end
        end
        ActStop: stop_armed = 1'b1;
        default: begin
          if (r.action == ActOpen) target = LimOpen;
          else target = LimClose;
          if (code == target) begin
            e.command_result = CmdAtTarget;
          end else if (mode == RunOpening || mode == RunClosing) begin
            e.command_result = CmdBusy;
          end else begin
            if (r.action == ActOpen) mode = RunOpening;
            else mode = RunClosing;
            fault = ErrOk;
            stop_armed = 1'b0;
            ticks = '0;
          end
        end
      endcase

      case (mode)
        RunClosing: begin
          e.motor_drive = DriveForward;
          e.host_status = HostClosing;
        end
        RunOpening: begin
          e.motor_drive = DriveReverse;
          e.host_status = HostOpening;
        end
        RunError: begin
          e.motor_drive = DriveStop;
          e.host_status = (fault == ErrTimeout) ? HostTimeout : lcode;
        end
        default: begin
          e.motor_drive = DriveStop;
          if (code == LimClose) e.host_status = HostClosed;
          else if (code == LimOpen) e.host_status = HostOpen;
          else e.host_status = lcode;
        end
      endcase
      e.run_mode = mode;
      e.fault_cause = fault;
      e.report_count = reports;
      e.limit_code = lcode;
      awaited_status.push_back(e);
    endfunction

    function void check_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", field, want, got);
        failures++;
      end
    endfunction

    function void check_response(rsp_t got);
      rsp_t want;
      if (awaited_status.size() == 0) begin
        $error("response with no request outstanding: %h", got);
        failures++;
        return;
      end
      want = awaited_status.pop_front();
      check_field("motor_drive", want.motor_drive, got.motor_drive);
      check_field("run_mode", want.run_mode, got.run_mode);
      check_field("fault_cause", want.fault_cause, got.fault_cause);
      check_field("command_result", want.command_result, got.command_result);
      check_field("report_count", want.report_count, got.report_count);
      check_field("limit_code", want.limit_code, got.limit_code);
      check_field("host_status", want.host_status, got.host_status);
    endfunction
  endclass

endpackage

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps
module testbench;
  import esms_pkg::*;
  import esms_scoreboard_pkg::*;

  localparam int unsigned CycleLimit = 2000000;
  localparam int unsigned PhaseItems = 200;
  localparam int unsigned PhaseCount = 6;

  logic clk;
  logic rst_ni;
  logic psel;
  logic penable;
  logic pwrite;
  logic [AddrW-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  esms_req_if req_if ();
  esms_rsp_if rsp_if ();

  endstop_motor_supervisor_unit dut (
    .clk_i   (clk),
    .rst_ni  (rst_ni),
    .req_i   (req_if),
    .rsp_o   (rsp_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  supervisor_scoreboard sb = new();

  bit no_idle = 1'b0;
  int hold_rsp_cycles = 0;
  int stall_left = 0;
  bit pin_close = 1'b0;
  bit pin_open = 1'b0;
  int unsigned cycle_count = 0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_ni) begin
      if (req_if.valid && req_if.ready) sb.note_request(req_if.data);
      if (rsp_if.valid && rsp_if.ready) sb.check_response(rsp_if.data);
    end
  end

  // Response side: random stalls, plus a long hold-off when one is asked for
  initial begin
    int roll;
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_rsp_cycles > 0) begin
        rsp_if.ready <= 1'b0;
        hold_rsp_cycles--;
      end else if (no_idle) begin
        rsp_if.ready <= 1'b1;
      end else if (stall_left > 0) begin
        rsp_if.ready <= 1'b0;
        stall_left--;
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 75) begin
          rsp_if.ready <= 1'b1;
        end else begin
          rsp_if.ready <= 1'b0;
          stall_left = (roll < 95) ? $urandom_range(0, 2) : $urandom_range(8, 25);
        end
      end
    end
  end

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (no_idle || roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  function automatic req_t pack_request(action_e act, bit close_on, bit open_on,
                                        bit fault_n, int unsigned sa, int unsigned sb_val);
    req_t r;
    r.action = act;
    r.close_limit_raw = close_on;
    r.open_limit_raw = open_on;
    r.fault_n = fault_n;
    r.sense_a = sa[11:0];
    r.sense_b = sb_val[11:0];
    return r;
  endfunction

  // Mostly plausible motion: sticky limit pins, currents under the limits,
  // rare faults; a small share of fully random noise
  function automatic req_t random_request();
    req_t r;
    int roll;
    if ($urandom_range(0, 19) == 0) begin
      r = req_t'($urandom);
      return r;
    end
    if ($urandom_range(0, 9) == 0) pin_close = ~pin_close;
    if ($urandom_range(0, 9) == 0) pin_open = ~pin_open;
    roll = $urandom_range(0, 99);
    if (roll < 68) r.action = ActTick;
    else if (roll < 78) r.action = ActOpen;
    else if (roll < 88) r.action = ActClose;
    else r.action = ActStop;
    r.close_limit_raw = pin_close;
    r.open_limit_raw = pin_open;
    r.fault_n = ($urandom_range(0, 29) != 0);
    r.sense_a = ($urandom_range(0, 19) == 0) ? 12'($urandom) : 12'($urandom_range(0, sb.limit_a));
    r.sense_b = ($urandom_range(0, 19) == 0) ? 12'($urandom) : 12'($urandom_range(0, sb.limit_b));
    return r;
  endfunction

  task automatic send_request(req_t r);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      req_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    req_if.valid <= 1'b1;
    req_if.data <= r;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    req_if.valid <= 1'b0;
    while (sb.awaited_status.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write, then read back over the same select
  task automatic write_register(reg_idx_e idx, logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.set_register(idx, value);
    @(negedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata != sb.register_value(idx)) begin
      $error("register %s: expected %0d, got %0d", idx.name(), sb.register_value(idx),
             prdata);
      sb.failures++;
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic write_setting(int unsigned lim_a, int unsigned lim_b, int unsigned tmo,
                               int unsigned deb);
    write_register(RegLimitA, lim_a);
    write_register(RegLimitB, lim_b);
    write_register(RegTimeout, tmo);
    write_register(RegDebounce, deb);
  endtask

  initial begin
    rst_ni = 1'b0;
    req_if.valid = 1'b0;
    req_if.data = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_ni <= 1'b1;

    write_setting(100, 200, 4, 1);
    send_request(pack_request(ActTick, 0, 0, 1, 0, 0));
    send_request(pack_request(ActTick, 1, 0, 1, 0, 0));
    send_request(pack_request(ActTick, 1, 0, 1, 0, 0));
    send_request(pack_request(ActClose, 1, 0, 1, 0, 0));
    send_request(pack_request(ActOpen, 1, 0, 1, 0, 0));
    send_request(pack_request(ActOpen, 0, 0, 1, 0, 0));
    send_request(pack_request(ActTick, 0, 1, 1, 50, 50));
    send_request(pack_request(ActClose, 0, 0, 1, 0, 0));
    send_request(pack_request(ActTick, 0, 0, 1, 101, 0));
    send_request(pack_request(ActClose, 0, 0, 1, 0, 0));
    send_request(pack_request(ActTick, 0, 0, 1, 100, 4095));
    send_request(pack_request(ActOpen, 0, 0, 1, 0, 0));
    // driver fault outranks overcurrent
    send_request(pack_request(ActTick, 0, 0, 0, 4095, 4095));
    send_request(pack_request(ActStop, 0, 0, 1, 0, 0));
    send_request(pack_request(ActClose, 1, 1, 1, 0, 0));
    send_request(pack_request(ActOpen, 1, 1, 1, 0, 0));
    send_request(pack_request(ActStop, 1, 1, 1, 0, 0));
    // stop outranks reaching the target
    send_request(pack_request(ActTick, 0, 1, 1, 0, 0));
    send_request(pack_request(ActClose, 0, 0, 1, 0, 0));
    repeat (5) send_request(pack_request(ActTick, 0, 0, 1, 0, 0));
    send_request(pack_request(ActTick, 1, 1, 0, 4095, 4095));
    wait_drained();

    for (int phase = 0; phase < PhaseCount; phase++) begin
      case (phase)
        0: write_setting(0, 0, 1, 15);
        1: write_setting(4095, 4095, 65535, 1);
        default: write_setting($urandom_range(1500, 4095), $urandom_range(1500, 4095),
                               $urandom_range(1, 40), $urandom_range(1, 6));
      endcase
      no_idle = (phase == 4);
      for (int n = 0; n < PhaseItems; n++) begin
        if (phase == 2 && n == 50) hold_rsp_cycles = 40;
        if (phase == 3 && n == 100) wait_drained();
        send_request(random_request());
      end
      wait_drained();
    end
    no_idle = 1'b0;

    wait_drained();
    repeat (6) @(posedge clk);
    if (sb.failures == 0 && sb.awaited_status.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/esms_pkg.sv
src/esms_req_if.sv
src/esms_rsp_if.sv
src/endstop_motor_supervisor_unit.sv
src/esms_checker.sv
verif/esms_scoreboard_pkg.sv
verif/testbench.sv
